// ===== sv/acf_pkg.sv =====
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants of the echo comb filter: field widths,
// register indexes, reset values and the items passed between its parts.
// ----------------------------------------------------------------------------
package acf_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int NORM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_FACTOR   = 2'd3;

    // register reset values
    localparam logic               RST_ECHO_MODE     = 1'b0;
    localparam logic [DELAY_W-1:0] RST_DELAY_SAMPLES = 17'd44100;
    localparam logic [GAIN_W-1:0]  RST_ECHO_GAIN     = 16'd26214;
    localparam logic [NORM_W-1:0]  RST_NORM_FACTOR   = 16'd36409;

    // saturation limits
    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    // settings the back end needs
    typedef struct packed {
        logic              echo_mode;
        logic [GAIN_W-1:0] echo_gain;
        logic [NORM_W-1:0] norm_factor;
    } cfg_t;

    // one classified sample
    typedef struct packed {
        logic                       echo;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

endpackage

// ===== sv/acf_in_if.sv =====
// ----------------------------------------------------------------------------
// acf_in_if
// Input sample channel: valid/ready handshake with one signed sample a beat.
// ----------------------------------------------------------------------------
interface acf_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [acf_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);

endinterface

// ===== sv/acf_out_if.sv =====
// ----------------------------------------------------------------------------
// acf_out_if
// Output sample channel: valid/ready handshake with one signed sample a beat.
// ----------------------------------------------------------------------------
interface acf_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [acf_pkg::SAMPLE_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);

endinterface

// ===== sv/acf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// acf_cfg_if
// Register write channel: valid/ready handshake with register index and data.
// ----------------------------------------------------------------------------
interface acf_cfg_if;

    logic                              valid;
    logic                              ready;
    logic [acf_pkg::CFG_IDX_W-1:0]     index;
    logic [acf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== sv/audio_echo_comb_filter.sv =====
// ----------------------------------------------------------------------------
// audio_echo_comb_filter
// Echo comb filter on signed 16-bit audio, one result sample per input beat.
//
// Channels: audio (input samples), echo (result samples), cfg (register
// writes: 0 echo mode, 1 delay in samples, 2 gain Q1.15, 3 normaliser Q0.16).
// Mode 0 gives a feed-forward single echo, mode 1 feedback multiple echoes.
// Until delay samples have been seen since reset, samples pass unchanged.
// Registers are to be written only while no sample is in flight; the block
// does not enforce this, and cfg never stalls.
// An echo sample passes through memory read, multiply-accumulate, normalising
// multiply, then saturate and write back; a pass-through sample goes straight
// to write back. The back-end sequencer around the single delay memory takes
// a new sample only as it writes the last one back.
// A two-entry queue decouples intake from processing, and the output
// register keeps a result while the receiver stalls, so audio keeps taking
// beats until the queue fills.
// Reset clears the pointer, fill count, queue and output valid and restores
// register defaults; the delay memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module audio_echo_comb_filter #(
    parameter int DELAY_DEPTH = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    acf_cfg_if.sink   cfg,
    acf_in_if.sink    audio,
    acf_out_if.source echo
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int QW = $bits(acf_pkg::item_t) + 2 * AW;

    logic                          push_valid;
    logic                          push_ready;
    acf_pkg::item_t                push_item;
    logic [AW-1:0]                 push_rd_addr;
    logic [AW-1:0]                 push_wr_addr;
    logic                          pop_valid;
    logic                          pop_ready;
    logic [QW-1:0]                 pop_data;
    acf_pkg::item_t                pop_item;
    logic [AW-1:0]                 pop_rd_addr;
    logic [AW-1:0]                 pop_wr_addr;
    acf_pkg::cfg_t                 settings;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [acf_pkg::SAMPLE_W-1:0]  mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [acf_pkg::SAMPLE_W-1:0]  mem_rdata;

    // intake and classification
    acf_front #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .audio        (audio),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item),
        .push_rd_addr (push_rd_addr),
        .push_wr_addr (push_wr_addr),
        .settings     (settings)
    );

    // decoupling queue
    acf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_item, push_rd_addr, push_wr_addr}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_item, pop_rd_addr, pop_wr_addr} = pop_data;

    // arithmetic and write back
    acf_back #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .pop_rd_addr (pop_rd_addr),
        .pop_wr_addr (pop_wr_addr),
        .settings    (settings),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .echo        (echo)
    );

    // delay memory
    acf_ram #(
        .WIDTH (acf_pkg::SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== sv/acf_ram.sv =====
// ----------------------------------------------------------------------------
// acf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module acf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acf_front.sv =====
// ----------------------------------------------------------------------------
// acf_front
// Front end: holds the settings, tracks the write pointer and fill count,
// and tags each sample as pass-through or echo with its memory addresses.
// ----------------------------------------------------------------------------
module acf_front #(
    parameter int DELAY_DEPTH = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    acf_cfg_if.sink                        cfg,
    acf_in_if.sink                         audio,
    output logic                           push_valid,
    input  logic                           push_ready,
    output acf_pkg::item_t                 push_item,
    output logic [$clog2(DELAY_DEPTH)-1:0] push_rd_addr,
    output logic [$clog2(DELAY_DEPTH)-1:0] push_wr_addr,
    output acf_pkg::cfg_t                  settings
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = $clog2(DELAY_DEPTH + 1);
    localparam int EW = (CW > acf_pkg::DELAY_W) ? CW : acf_pkg::DELAY_W;

    logic                          echo_mode_reg;
    logic [acf_pkg::DELAY_W-1:0]   delay_reg;
    logic [acf_pkg::GAIN_W-1:0]    gain_reg;
    logic [acf_pkg::NORM_W-1:0]    norm_reg;
    logic [AW-1:0]                 wp_reg;
    logic [AW-1:0]                 wp_next;
    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 fill_next;
    logic [EW-1:0]                 delay_x;
    logic [CW-1:0]                 delay_eff;
    logic [CW-1:0]                 wp_x;
    logic [CW-1:0]                 rd_full;
    logic                          beat;

    // register writes, never stalled
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_mode_reg <= acf_pkg::RST_ECHO_MODE;
            delay_reg     <= acf_pkg::RST_DELAY_SAMPLES;
            gain_reg      <= acf_pkg::RST_ECHO_GAIN;
            norm_reg      <= acf_pkg::RST_NORM_FACTOR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                acf_pkg::REG_ECHO_MODE:     echo_mode_reg <= cfg.data[0];
                acf_pkg::REG_DELAY_SAMPLES: delay_reg     <= cfg.data;
                acf_pkg::REG_ECHO_GAIN:     gain_reg      <= cfg.data[acf_pkg::GAIN_W-1:0];
                acf_pkg::REG_NORM_FACTOR:   norm_reg      <= cfg.data[acf_pkg::NORM_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign settings.echo_mode   = echo_mode_reg;
    assign settings.echo_gain   = gain_reg;
    assign settings.norm_factor = norm_reg;

    // effective delay, clamped to 1..depth
    always_comb
    begin
        delay_x = EW'(delay_reg);
        if (delay_x == '0)
        begin
            delay_eff = CW'(1);
        end
        else if (delay_x > EW'(DELAY_DEPTH))
        begin
            delay_eff = CW'(DELAY_DEPTH);
        end
        else
        begin
            delay_eff = CW'(delay_x);
        end
    end

    // read address wraps below zero back into the ring
    assign wp_x = CW'(wp_reg);

    always_comb
    begin
        if (wp_x >= delay_eff)
        begin
            rd_full = wp_x - delay_eff;
        end
        else
        begin
            rd_full = (CW'(DELAY_DEPTH) - delay_eff) + wp_x;
        end
    end

    // classification and hand-off to the queue
    assign beat              = audio.valid && push_ready;
    assign audio.ready       = push_ready;
    assign push_valid        = audio.valid;
    assign push_item.echo    = (fill_reg >= delay_eff);
    assign push_item.sample  = audio.in_sample;
    assign push_rd_addr      = rd_full[AW-1:0];
    assign push_wr_addr      = wp_reg;

    // pointer and fill count advance
    assign wp_next   = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_next = (fill_reg < CW'(DELAY_DEPTH)) ? fill_reg + CW'(1) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (beat)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== sv/acf_queue.sv =====
// ----------------------------------------------------------------------------
// acf_queue
// Two-entry queue between the front and back ends, so each can stall alone.
// ----------------------------------------------------------------------------
module acf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/acf_back.sv =====
// ----------------------------------------------------------------------------
// acf_back
// Back end: for an echo sample reads the delayed sample, forms x*2^15 + g*d,
// scales by the normaliser, truncates and saturates; for every sample it updates
// the delay memory and holds the result in the output register.
// ----------------------------------------------------------------------------
module acf_back #(
    parameter int DELAY_DEPTH = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  acf_pkg::item_t                      pop_item,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      pop_rd_addr,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      pop_wr_addr,
    input  acf_pkg::cfg_t                       settings,
    output logic                                mem_we,
    output logic [$clog2(DELAY_DEPTH)-1:0]      mem_waddr,
    output logic [acf_pkg::SAMPLE_W-1:0]        mem_wdata,
    output logic [$clog2(DELAY_DEPTH)-1:0]      mem_raddr,
    input  logic [acf_pkg::SAMPLE_W-1:0]        mem_rdata,
    acf_out_if.source                           echo
);

    localparam int AW = $clog2(DELAY_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic                                echo_reg;
    logic signed [acf_pkg::SAMPLE_W-1:0] sample_reg;
    logic [AW-1:0]                       rd_addr_reg;
    logic [AW-1:0]                       wr_addr_reg;
    logic signed [32:0]                  acc_reg;
    logic signed [32:0]                  acc_next;
    logic [47:0]                         prod_reg;
    logic [47:0]                         prod_next;
    logic                                neg_reg;
    logic signed [32:0]                  gain_x;
    logic signed [32:0]                  past_x;
    logic signed [32:0]                  x_x;
    logic [31:0]                         mag;
    logic [16:0]                         quot;
    logic [acf_pkg::SAMPLE_W-1:0]        scaled;
    logic [acf_pkg::SAMPLE_W-1:0]        result;
    logic                                out_valid_reg;
    logic [acf_pkg::SAMPLE_W-1:0]        out_sample_reg;
    logic                                done;
    logic                                take;

    // handshake with queue and output register
    assign done      = (state_reg == S_OUT) && (!out_valid_reg || echo.ready);
    assign pop_ready = (state_reg == S_IDLE) || done;
    assign take      = pop_valid && pop_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = pop_item.echo ? S_READ : S_OUT;
                end
            end
            S_READ:  state_next = S_MAC;
            S_MAC:   state_next = S_SCALE;
            S_SCALE: state_next = S_OUT;
            S_OUT:
            begin
                if (done)
                begin
                    if (take)
                    begin
                        state_next = pop_item.echo ? S_READ : S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            echo_reg    <= pop_item.echo;
            sample_reg  <= pop_item.sample;
            rd_addr_reg <= pop_rd_addr;
            wr_addr_reg <= pop_wr_addr;
        end
    end

    // delayed sample read
    assign mem_raddr = rd_addr_reg;

    // x*2^15 + g*d, exact in 33 bits
    assign gain_x   = 33'($signed({1'b0, settings.echo_gain}));
    assign past_x   = 33'($signed(mem_rdata));
    assign x_x      = {{2{sample_reg[15]}}, sample_reg, 15'b0};
    assign acc_next = x_x + gain_x * past_x;

    // magnitude times normaliser, sign kept aside
    assign mag       = acc_reg[32] ? 32'(-acc_reg) : acc_reg[31:0];
    assign prod_next = 48'(mag) * 48'(settings.norm_factor);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MAC)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == S_SCALE)
        begin
            prod_reg <= prod_next;
            neg_reg  <= acc_reg[32];
        end
    end

    // drop 31 fraction bits, restore sign, saturate
    assign quot = prod_reg[47:31];

    always_comb
    begin
        if (neg_reg)
        begin
            if (quot >= 17'd32768)
            begin
                scaled = acf_pkg::SAT_NEG;
            end
            else
            begin
                scaled = 16'(~quot[15:0] + 16'd1);
            end
        end
        else
        begin
            if (quot > 17'd32767)
            begin
                scaled = acf_pkg::SAT_POS;
            end
            else
            begin
                scaled = quot[15:0];
            end
        end
    end

    assign result = echo_reg ? scaled : sample_reg;

    // delay memory update: inputs for single echo, outputs for feedback
    assign mem_we    = done;
    assign mem_waddr = wr_addr_reg;
    assign mem_wdata = settings.echo_mode ? result : sample_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (echo.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_sample_reg <= result;
        end
    end

    assign echo.valid      = out_valid_reg;
    assign echo.out_sample = $signed(out_sample_reg);

endmodule

// ===== sv/acf_checker.sv =====
// ----------------------------------------------------------------------------
// acf_checker
// Port-level checks of the echo comb filter, bound to the top level.
// ----------------------------------------------------------------------------
module acf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_ready,
    input logic                         echo_valid,
    input logic                         echo_ready,
    input logic [acf_pkg::SAMPLE_W-1:0] echo_sample
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && !echo_ready |=> echo_valid)
        else $error("result beat withdrawn while stalled");

    // a stalled result beat keeps its sample
    assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && !echo_ready |=> $stable(echo_sample))
        else $error("result sample changed while stalled");

    // no result is offered while in reset
    assert property (@(posedge clk) !rst_n |-> !echo_valid)
        else $error("result offered during reset");

    // register writes are never back-pressured
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("register write channel stalled");

endmodule

bind audio_echo_comb_filter acf_checker u_acf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg.ready),
    .echo_valid  (echo.valid),
    .echo_ready  (echo.ready),
    .echo_sample (echo.out_sample)
);
